// File: hdl/itoa_pkg.sv
// itoa_pkg: shared types, character constants and the digit-to-ASCII helper
// for the integer-to-ASCII radix converter. No dependencies.
package itoa_pkg;

	localparam logic [6:0] CHAR_ZERO  = 7'h30;  // '0'
	localparam logic [6:0] CHAR_MINUS = 7'h2D;  // '-'
	localparam logic [6:0] ALPHA_GAP  = 7'd7;   // distance from '9'+1 to 'A'
	localparam logic [5:0] DIGIT_MAX  = 6'd9;
	localparam logic [5:0] RADIX_MIN  = 6'd2;
	localparam logic [5:0] RADIX_MAX  = 6'd36;

	// dividend bits retired per divider cycle
	localparam int BITS_PER_CYC = 8;

	typedef struct packed {
		logic err;  // radix out of range
		logic neg;  // emit leading minus, magnitude already negated
	} itoa_flags_t;

	function automatic logic [6:0] digit_char(input logic [5:0] d);
		logic [6:0] base;
		base = 7'(d) + CHAR_ZERO;
		return (d > DIGIT_MAX) ? base + ALPHA_GAP : base;
	endfunction

endpackage

// File: hdl/itoa_ram.sv
// itoa_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module itoa_ram #(
	parameter int WIDTH = 6,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: hdl/itoa_front.sv
// itoa_front: classifies an incoming request (radix check, sign, magnitude).
// Depends on itoa_pkg.
module itoa_front #(
	parameter int VALUE_BITS = 32
) (
	input  logic [31:0]             value,
	input  logic                    is_signed,
	input  logic [5:0]              radix,
	output itoa_pkg::itoa_flags_t   flags,
	output logic [VALUE_BITS-1:0]   mag
);
	import itoa_pkg::*;

	logic [VALUE_BITS-1:0] v;

	assign v = VALUE_BITS'(value);

	always_comb begin
		flags.err = !(radix inside {[RADIX_MIN:RADIX_MAX]});
		flags.neg = is_signed && v[VALUE_BITS-1];
		// two's complement negate, so the most negative value maps onto itself
		mag = flags.neg ? (~v) + VALUE_BITS'(1) : v;
	end

endmodule

// File: hdl/itoa_queue.sv
// itoa_queue: two-entry request queue between classifier and converter.
// No dependencies.
module itoa_queue #(
	parameter int WIDTH = 40
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output logic [WIDTH-1:0] pop_data
);

	logic [WIDTH-1:0] entry_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign pop_data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: hdl/itoa_back.sv
// itoa_back: radix conversion engine. Serial restoring divider produces the
// digits LSD first into the digit RAM, then they are read back MSD first.
// Depends on itoa_pkg and itoa_ram.
module itoa_back #(
	parameter int VALUE_BITS = 32,
	parameter int MAX_DIGITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_pop,
	input  itoa_pkg::itoa_flags_t cmd_flags,
	input  logic [5:0]            cmd_radix,
	input  logic [VALUE_BITS-1:0] cmd_mag,
	input  logic                  out_stall,
	output logic                  out_valid,
	output logic [6:0]            ascii_char,
	output logic                  last,
	output logic                  error
);
	import itoa_pkg::*;

	localparam int NCYC = (VALUE_BITS + BITS_PER_CYC - 1) / BITS_PER_CYC;
	localparam int PB   = NCYC * BITS_PER_CYC;
	localparam int SW   = (NCYC > 1) ? $clog2(NCYC) : 1;
	localparam int AW   = $clog2(MAX_DIGITS);
	localparam int CW   = $clog2(MAX_DIGITS + 1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DIV  = 4'b0010,
		ST_READ = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t          state_q;
	logic [PB-1:0]   work_q;
	logic [5:0]      rem_q;
	logic [5:0]      radix_q;
	logic [SW-1:0]   step_q;
	logic [CW-1:0]   dcnt_q;
	logic [AW-1:0]   rd_idx_q;
	logic            out_valid_q;
	logic [6:0]      char_q;
	logic            last_q;
	logic            err_q;

	logic            out_free;
	logic            out_load;
	logic            digit_done;
	logic            conv_done;
	logic [PB-1:0]   work_nx;
	logic [5:0]      rem_nx;
	logic [5:0]      rd_digit;

	assign out_free   = !out_valid_q || !out_stall;
	assign cmd_pop    = (state_q == ST_IDLE) && cmd_valid && out_free;
	assign digit_done = (state_q == ST_DIV) && (step_q == SW'(NCYC - 1));
	assign conv_done  = (work_nx == '0) || (dcnt_q == CW'(MAX_DIGITS - 1));
	// output register takes a new character this cycle
	assign out_load   = (cmd_pop && (cmd_flags.err || cmd_flags.neg))
	                 || ((state_q == ST_EMIT) && out_free);

	assign out_valid  = out_valid_q;
	assign ascii_char = char_q;
	assign last       = last_q;
	assign error      = err_q;

	// BITS_PER_CYC restoring steps on a narrow remainder
	always_comb begin
		logic [6:0] r7;
		logic [5:0] r;
		logic [PB-1:0] w;
		r = rem_q;
		w = work_q;
		for (int k = 0; k < BITS_PER_CYC; k++) begin
			r7 = {r, w[PB-1]};
			w  = {w[PB-2:0], 1'b0};
			if (r7 >= {1'b0, radix_q}) begin
				r7   = r7 - {1'b0, radix_q};
				w[0] = 1'b1;
			end
			r = r7[5:0];
		end
		rem_nx  = r;
		work_nx = w;
	end

	itoa_ram #(
		.WIDTH(6),
		.DEPTH(MAX_DIGITS)
	) u_digits (
		.clk  (clk),
		.we   (digit_done),
		.waddr(dcnt_q[AW-1:0]),
		.wdata(rem_nx),
		.re   (state_q == ST_READ),
		.raddr(rd_idx_q),
		.rdata(rd_digit)
	);

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (cmd_pop) begin
					work_q  <= PB'(cmd_mag);
					radix_q <= cmd_radix;
					rem_q   <= '0;
				end
				if (cmd_pop && (cmd_flags.err || cmd_flags.neg)) begin
					char_q <= cmd_flags.err ? 7'd0 : CHAR_MINUS;
					last_q <= cmd_flags.err;
					err_q  <= cmd_flags.err;
				end
			end
			ST_DIV: begin
				work_q <= work_nx;
				rem_q  <= digit_done ? 6'd0 : rem_nx;
				if (digit_done) begin
					rd_idx_q <= dcnt_q[AW-1:0];
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					char_q   <= digit_char(rd_digit);
					last_q   <= (rd_idx_q == '0);
					err_q    <= 1'b0;
					rd_idx_q <= rd_idx_q - AW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			dcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_pop) begin
						step_q <= '0;
						dcnt_q <= '0;
						if (!cmd_flags.err) begin
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (digit_done) begin
						step_q <= '0;
						dcnt_q <= dcnt_q + CW'(1);
						if (conv_done) begin
							state_q <= ST_READ;
						end
					end else begin
						step_q <= step_q + SW'(1);
					end
				end
				ST_READ: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= (rd_idx_q == '0) ? ST_IDLE : ST_READ;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: hdl/integer_to_ascii_radix_core.sv
// integer_to_ascii_radix_core: top level of the integer-to-ASCII converter.
// Depends on itoa_pkg, itoa_front, itoa_queue, itoa_back (and itoa_ram).
//
//   channel  handshake              payload
//   -------  ---------------------  ------------------------------
//   in       in_valid / in_stall    value[31:0], is_signed, radix[5:0]
//   out      out_valid / out_stall  ascii_char[6:0], last, error
//
// A request is picked up from the queue; the shared serial divider then
// produces its digits one after another into the digit RAM, and each
// character is read back through the RAM read port and then emitted.
// The minus sign goes out as the request is picked up.
// A bad radix gives one error result. Up to two requests wait in the
// queue, so in_stall rises only when it is full. out_stall holds the output
// register and freezes character emission; division goes on until it needs
// the output. Reset (arst_n low) empties the queue and idles the engine; the
// digit RAM needs no clearing since every conversion writes before it reads.
module integer_to_ascii_radix_core #(
	parameter int VALUE_BITS = 32,
	parameter int MAX_DIGITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] value,
	input  logic        is_signed,
	input  logic [5:0]  radix,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [6:0]  ascii_char,
	output logic        last,
	output logic        error
);
	import itoa_pkg::*;

	localparam int QW = $bits(itoa_flags_t) + 6 + VALUE_BITS;

	itoa_flags_t           fr_flags;
	logic [VALUE_BITS-1:0] fr_mag;
	logic                  q_full;
	logic                  q_not_empty;
	logic                  q_pop;
	logic [QW-1:0]         q_data;
	itoa_flags_t           cmd_flags;
	logic [5:0]            cmd_radix;
	logic [VALUE_BITS-1:0] cmd_mag;

	// classify the request as it arrives
	itoa_front #(
		.VALUE_BITS(VALUE_BITS)
	) u_front (
		.value    (value),
		.is_signed(is_signed),
		.radix    (radix),
		.flags    (fr_flags),
		.mag      (fr_mag)
	);

	assign in_stall = q_full;

	// decouples request intake from the conversion engine
	itoa_queue #(
		.WIDTH(QW)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (in_valid && !q_full),
		.push_data({fr_flags, radix, fr_mag}),
		.full     (q_full),
		.pop      (q_pop),
		.not_empty(q_not_empty),
		.pop_data (q_data)
	);

	assign {cmd_flags, cmd_radix, cmd_mag} = q_data;

	itoa_back #(
		.VALUE_BITS(VALUE_BITS),
		.MAX_DIGITS(MAX_DIGITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_not_empty),
		.cmd_pop   (q_pop),
		.cmd_flags (cmd_flags),
		.cmd_radix (cmd_radix),
		.cmd_mag   (cmd_mag),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.ascii_char(ascii_char),
		.last      (last),
		.error     (error)
	);

endmodule

// File: hdl/itoa_checker.sv
// itoa_checker: port-level assertions for integer_to_ascii_radix_core,
// attached by bind. Depends on itoa_pkg.
module itoa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [6:0]  ascii_char,
	input logic        last,
	input logic        error
);
	import itoa_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(ascii_char) && $stable(last)
			&& $stable(error))
		else $error("stalled result changed");

	// input stall only rises after a request was taken
	a_stall_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(in_valid))
		else $error("in_stall rose without a request");

	// error result is a lone zero character
	a_err_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error |-> ascii_char == 7'd0 && last)
		else $error("bad error result");

	// minus sign is never the final character
	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !error && ascii_char == CHAR_MINUS |-> !last)
		else $error("minus marked last");

	// a normal character is a minus, a decimal digit or an upper-case letter
	a_char_set: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !error |-> ascii_char == CHAR_MINUS
			|| (ascii_char >= 7'h30 && ascii_char <= 7'h39)
			|| (ascii_char >= 7'h41 && ascii_char <= 7'h5A))
		else $error("character out of set");

endmodule

bind integer_to_ascii_radix_core itoa_checker u_itoa_checker (.*);

// File: sim/testbench.sv
// testbench: self-checking bench for integer_to_ascii_radix_core.
// Depends on itoa_pkg and the converter RTL; predicts every character of each
// conversion and compares it with the output stream in order.
module testbench;
	import itoa_pkg::*;

	localparam logic [6:0] CHAR_A         = 7'h41;  // 'A', first digit above nine
	localparam int         WATCHDOG_LIMIT = 4000;   // cycles with no transfer
	localparam int         TAIL_CYCLES    = 300;    // cycles run after all expected text is out
	localparam int         RANDOM_REQS    = 80;

	// one conversion request as the sender holds it
	typedef struct {
		logic [31:0] val;
		logic        sgn;
		logic [5:0]  rdx;
		bit          drain;  // hold this one back until all text is out
	} conv_req_t;

	// one predicted output character
	typedef struct packed {
		logic [6:0] ch;
		logic       fin;
		logic       err;
	} glyph_t;

	logic        clk;
	logic        arst_n     = 1'b0;
	logic        in_valid   = 1'b0;
	logic        in_stall;
	logic [31:0] value      = '0;
	logic        is_signed  = 1'b0;
	logic [5:0]  radix      = '0;
	logic        out_valid;
	logic        out_stall  = 1'b0;
	logic [6:0]  ascii_char;
	logic        last;
	logic        error;

	conv_req_t pend_q[$];     // requests not yet offered
	glyph_t    text_q[$];     // characters still owed by the block
	logic      in_took = 1'b0;
	int        reqs_in = 0;   // requests accepted so far
	int        errors  = 0;
	int        idle_cycles = 0;

	// sender pacing
	int burst_left = 4;
	int gap_left   = 0;

	// receiver pacing
	int rx_mode     = 0;
	int rx_phase    = 0;
	int hold_left   = 0;
	int next_hold   = 40;     // request count that triggers the next long hold-off

	integer_to_ascii_radix_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.value     (value),
		.is_signed (is_signed),
		.radix     (radix),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.ascii_char(ascii_char),
		.last      (last),
		.error     (error)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Expected text of one conversion. Bad radix: a single flagged NUL.
	// Signed negative: '-' then the two's complement magnitude, so the most
	// negative value still converts. Digits are produced LSD first and
	// emitted MSD first; zero gives one '0'.
	function automatic void predict_text(input logic [31:0] v, input logic sgn,
		input logic [5:0] rdx);
		logic [31:0] mag;
		logic [5:0]  digs[32];
		logic [5:0]  d;
		int          n;
		glyph_t      g;
		if (rdx < RADIX_MIN || rdx > RADIX_MAX) begin
			g = '{ch: 7'd0, fin: 1'b1, err: 1'b1};
			text_q.push_back(g);
			return;
		end
		mag = v;
		if (sgn && v[31]) begin
			g = '{ch: CHAR_MINUS, fin: 1'b0, err: 1'b0};
			text_q.push_back(g);
			mag = 32'd0 - v;
		end
		n = 0;
		do begin
			digs[n] = 6'(mag % 32'(rdx));
			mag     = mag / 32'(rdx);
			n++;
		end while (mag != 0 && n < 32);
		for (int i = n - 1; i >= 0; i--) begin
			d    = digs[i];
			g.ch = (d > DIGIT_MAX) ? CHAR_A + 7'(d - DIGIT_MAX - 6'd1)
			                       : CHAR_ZERO + 7'(d);
			g.fin = (i == 0);
			g.err = 1'b0;
			text_q.push_back(g);
		end
	endfunction

	task automatic queue_conv(input logic [31:0] v, input logic s, input logic [5:0] r,
		input bit d);
		conv_req_t q;
		q = '{val: v, sgn: s, rdx: r, drain: d};
		pend_q.push_back(q);
	endtask

	// Random value shaped by radix: full range, small, just around a power
	// of the radix (digit count boundaries), sign extremes, small negatives, shifted words.
	function automatic logic [31:0] pick_value(input logic [5:0] r);
		logic [63:0] p;
		int          k;
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return 32'($urandom_range(0, 40));
			2: begin
				if (r < RADIX_MIN) return $urandom;
				p = 64'd1;
				k = $urandom_range(1, 31);
				repeat (k) if (p * r <= 64'hFFFF_FFFF) p = p * r;
				return 32'(p) - 32'($urandom_range(0, 1));
			end
			3: case ($urandom_range(0, 3))
				0: return 32'h7FFF_FFFF;
				1: return 32'h8000_0000;
				2: return 32'h8000_0001;
				default: return 32'hFFFF_FFFF;
			endcase
			4: return 32'd0 - 32'($urandom_range(1, 1000));
			default: return $urandom >> $urandom_range(0, 31);
		endcase
	endfunction

	// Stimulus and end of run
	initial begin : stim
		logic [5:0] r;
		// directed: zero, widest outputs, sign extremes, digit alphabet edges,
		// out-of-range radix on both sides
		queue_conv(32'd0,          1'b0, 6'd10, 1'b0);
		queue_conv(32'd0,          1'b1, 6'd2,  1'b0);
		queue_conv(32'hFFFF_FFFF,  1'b0, 6'd2,  1'b0);  // 32 digits
		queue_conv(32'h8000_0000,  1'b1, 6'd2,  1'b0);  // '-' + 32 digits
		queue_conv(32'h8000_0000,  1'b1, 6'd10, 1'b0);
		queue_conv(32'h8000_0000,  1'b0, 6'd10, 1'b0);
		queue_conv(32'hFFFF_FFFF,  1'b1, 6'd10, 1'b0);  // -1
		queue_conv(32'h7FFF_FFFF,  1'b1, 6'd36, 1'b0);
		queue_conv(32'hFFFF_FFFF,  1'b0, 6'd36, 1'b0);
		queue_conv(32'd35,         1'b0, 6'd36, 1'b0);  // 'Z'
		queue_conv(32'd10,         1'b0, 6'd11, 1'b0);  // 'A'
		queue_conv(32'd9,          1'b0, 6'd10, 1'b0);
		queue_conv(32'd10,         1'b0, 6'd10, 1'b0);
		queue_conv(32'hDEAD_BEEF,  1'b0, 6'd16, 1'b0);
		queue_conv(32'hDEAD_BEEF,  1'b1, 6'd16, 1'b0);
		queue_conv(32'o1234567,    1'b1, 6'd8,  1'b0);
		queue_conv(32'd3486784401, 1'b0, 6'd3,  1'b0);  // 3^20
		queue_conv(32'hFFFF_FFFF,  1'b1, 6'd0,  1'b0);
		queue_conv(32'd5,          1'b0, 6'd1,  1'b0);
		queue_conv(32'h8000_0000,  1'b1, 6'd37, 1'b0);
		queue_conv(32'h1234_5678,  1'b0, 6'd63, 1'b1);  // sender waits for drain
		queue_conv(32'd1,          1'b1, 6'd2,  1'b0);

		for (int i = 0; i < RANDOM_REQS; i++) begin
			if ($urandom_range(0, 9) == 0)
				r = 6'($urandom_range(0, 63));
			else
				r = 6'($urandom_range(2, 36));
			queue_conv(pick_value(r), 1'($urandom), r,
				(i == 60) || ($urandom_range(0, 24) == 0));
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pend_q.size() != 0 || in_valid) @(posedge clk);
		while (text_q.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (errors == 0 && text_q.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Sender: one valid update per falling edge. A request stays up until
	// taken; bursts of random length alternate with random gaps, and a
	// long burst with no gap now and then.
	always @(negedge clk) begin : drive
		logic      nv;
		conv_req_t nx;
		if (arst_n) begin
			nv = in_valid;
			if (in_valid && in_took)
				nv = 1'b0;
			if (!nv) begin
				if (gap_left != 0)
					gap_left--;
				else if (pend_q.size() != 0 && !(pend_q[0].drain && text_q.size() != 0)) begin
					nx = pend_q.pop_front();
					nv = 1'b1;
					value     <= nx.val;
					is_signed <= nx.sgn;
					radix     <= nx.rdx;
					burst_left--;
					if (burst_left <= 0) begin
						if ($urandom_range(0, 4) == 0) begin
							burst_left = $urandom_range(15, 30);
							gap_left   = 0;
						end else begin
							burst_left = $urandom_range(1, 8);
							gap_left   = $urandom_range(1, 60);
						end
					end
				end
			end
			in_valid <= nv;
		end
	end

	// Receiver: the stall mode is redrawn at random among none, light, heavy
	// and alternating. Twice the receiver holds off while the sender keeps
	// going, so the request queue fills and in_stall has to rise.
	always @(negedge clk) begin : sink
		logic st;
		if (arst_n) begin
			if (hold_left == 0 && reqs_in >= next_hold && next_hold < 100) begin
				hold_left = $urandom_range(400, 600);
				next_hold = next_hold + 45;
			end
			if (rx_phase == 0) begin
				rx_mode  = $urandom_range(0, 3);
				rx_phase = 50;
			end
			rx_phase--;
			if (hold_left != 0) begin
				st = 1'b1;
				hold_left--;
			end else begin
				case (rx_mode)
					0:       st = 1'b0;
					1:       st = ($urandom_range(0, 3) == 0);
					2:       st = ($urandom_range(0, 3) != 0);
					default: st = rx_phase[0];
				endcase
			end
			out_stall <= st;
		end
	end

	// Both transfers are sampled at the rising edge; a taken request is
	// predicted right there, so the owed text is queued before any of
	// its characters can appear.
	always @(posedge clk) begin : watch
		glyph_t w;
		in_took <= in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall) begin
			predict_text(value, is_signed, radix);
			reqs_in++;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (text_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected char %h last %b error %b", ascii_char, last, error);
			end else begin
				w = text_q.pop_front();
				if (ascii_char !== w.ch || last !== w.fin || error !== w.err) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: want char %h last %b error %b, got %h %b %b",
							w.ch, w.fin, w.err, ascii_char, last, error);
				end
			end
		end
	end

	// Watchdog: any transfer on either side resets the count.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else if (arst_n) begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

endmodule
